/* sv/ple_pkg.sv */
// Shared types and constants for the positional list engine.
// Depends on nothing; imported by the controller, the datapath and the top level.
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int CELL_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int KIND_W   = 3;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;

  localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_AT     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] NONE_VALUE = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted request
    logic exec;   // apply the held request and load the result register
  } ple_cmd_t;

endpackage

/* sv/ple_ctrl.sv */
// Controller of the positional list engine: request handshake, sequencing
// and result valid. Depends on ple_pkg.
module ple_ctrl
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output ple_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the request until the result register can take it
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/ple_datapath.sv */
// Datapath of the positional list engine: request register, shifting cell
// row, length count and result register. Depends on ple_pkg.
module ple_datapath
  import ple_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ple_cmd_t                cmd,
  input  logic [KIND_W-1:0]       kind,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic signed [VAL_W-1:0] read_value,
  output logic [STAT_W-1:0]       status,
  output logic [LEN_W-1:0]        list_length
);

  logic [KIND_W-1:0]       kind_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] val_r;

  logic [VAL_W-1:0] cells_r   [CAPACITY];
  logic [VAL_W-1:0] cells_nxt [CAPACITY];
  logic [LEN_W-1:0] len_r, len_nxt;

  logic [VAL_W-1:0]  rv_r, rv_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [LEN_W-1:0]  olen_r;

  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] ins_pos;
  logic             pos_in;
  logic             do_ins, do_del;

  assign len_ext = POS_W'(len_r);
  assign pos_in  = (pos_r < len_ext);

  always_comb begin
    case (kind_r)
      KIND_HEAD: ins_pos = '0;
      KIND_TAIL: ins_pos = len_ext;
      default:   ins_pos = pos_r;
    endcase
  end

  always_comb begin
    rv_nxt  = NONE_VALUE;
    st_nxt  = ST_RANGE;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    case (kind_r)
      KIND_READ: begin
        if (pos_in) begin
          rv_nxt = cells_r[pos_r[CELL_W-1:0]];
          st_nxt = ST_DONE;
        end
      end
      KIND_HEAD, KIND_TAIL, KIND_AT: begin
        if (ins_pos > len_ext) begin
          st_nxt = ST_RANGE;
        end else if (len_r == LEN_W'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else begin
          st_nxt = ST_DONE;
          do_ins = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos_in) begin
          st_nxt = ST_DONE;
          do_del = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_RANGE;
      end
    endcase
  end

  // Each cell looks only at its own neighbours.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (POS_W'(i) == ins_pos) begin
          cells_nxt[i] = val_r;
        end else if ((i > 0) && (POS_W'(i) > ins_pos)) begin
          cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if ((i < CAPACITY - 1) && (POS_W'(i) >= pos_r)) begin
          cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (do_ins) begin
      len_nxt = len_r + 1'b1;
    end else if (do_del) begin
      len_nxt = len_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.exec) begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      pos_r  <= position;
      val_r  <= item_value;
    end
    if (cmd.exec) begin
      cells_r <= cells_nxt;
      rv_r    <= rv_nxt;
      st_r    <= st_nxt;
      olen_r  <= len_nxt;
    end
  end

  assign read_value  = rv_r;
  assign status      = st_r;
  assign list_length = olen_r;

endmodule

/* sv/positional_list_engine.sv */
// Positional list engine: an ordered list of up to CAPACITY signed values.
// A result beat becomes valid after its request beat is captured in the request register
// and then applied in EXEC; a new request is accepted only after the current one is applied,
// as the shift of the cell row follows the request register; a waiting result stalls only EXEC.
// Reset (rst_n low, synchronous): empties the list and drops any pending result;
// the cells themselves are not cleared, as only cells below the length are read.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] item_value
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [37:32] list_length, [39:38] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  ple_cmd_t cmd;

  logic signed [VAL_W-1:0] read_value;
  logic [STAT_W-1:0]       status;
  logic [LEN_W-1:0]        list_length;

  // Sequence each beat: capture on accept, then apply once the result slot is free.
  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Hold the list in a row of cells that shift on insert or delete.
  ple_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .kind        (in_tuser),
    .position    (in_tdata[7:0]),
    .item_value  (in_tdata[39:8]),
    .read_value  (read_value),
    .status      (status),
    .list_length (list_length)
  );

  // Pack the result beat; pad the spare top bits with zeros.
  assign out_tdata = {2'b00, list_length, read_value};
  assign out_tuser = status;

`ifndef ASSERT_OFF
  // A full rejection can only come from a list holding CAPACITY entries.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_FULL)) |-> (out_tdata[37:32] == LEN_W'(CAPACITY)))
    else $error("full status with list not at capacity");

  // Anything other than the none value must be a read hit.
  a_value_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[31:0] != NONE_VALUE)) |-> (out_tuser == ST_DONE))
    else $error("value returned without done status");

  // The length never passes capacity.
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37:32] <= LEN_W'(CAPACITY)))
    else $error("list length beyond capacity");

  // One request at a time: no new beat in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");
`endif

endmodule
